FILE: rtl/can_frame_text_parser_unit_defines.svh
// assertion macros for the can frame text parser
// used by the top level only, needs nothing else
`ifndef CAN_FRAME_TEXT_PARSER_UNIT_DEFINES_SVH
`define CAN_FRAME_TEXT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CFTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cftp_pkg.sv
// shared types and constants of the can frame text parser
// no dependencies
`default_nettype none

package cftp_pkg;

  localparam int DefMaxDataBytes = 8;

  localparam logic [7:0] CharHash = 8'h23;  // '#'
  localparam logic [7:0] CharDot  = 8'h2E;  // '.'
  localparam logic [7:0] CharR    = 8'h52;  // 'R'
  localparam logic [7:0] CharRLow = 8'h72;  // 'r'

  // decoded view of one character
  typedef struct packed {
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_hash;
    logic       is_dot;
    logic       is_rtr;
    logic       dlc_ok;   // hex digit 0 to 8
  } char_class_t;

  // one result transfer
  typedef struct packed {
    logic        status;
    logic [11:0] can_id;
    logic        remote_request;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/can_frame_text_parser_unit.sv
// top level of the can frame text parser: input register, decoder, parser
// depends on cftp_pkg, cftp_char_class, cftp_parser and the defines header
//
// usage
// - input channel: one ascii character per transfer on char_code_i, with
//   is_last_i high on the final character of a frame text such as 123#DEADBEEF
// - output channel: one result per text (status, can_id, remote_request,
//   data_length, payload), nothing for the characters before the last
// - throughput: one character per cycle unless a last character is stalled;
//   the parse state is a single register set updated by one pass of short logic per character
// - result path: a last character is held first in the input register and
//   then in the result register (one stage in each), with a stall possible
//   between them while the result register is occupied
// - stall: characters that are not last keep flowing while a result waits;
//   a last character holds in the input register until the result register
//   is free, and in_ready_o drops once that register is also occupied
// - reset: all state clears, the parser waits for the first identifier
//   digit, no result is pending
`default_nettype none

`include "can_frame_text_parser_unit_defines.svh"

module can_frame_text_parser_unit #(
  parameter int MaxDataBytes = cftp_pkg::DefMaxDataBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [11:0]      can_id_o,
  output logic             remote_request_o,
  output logic [3:0]       data_length_o,
  output logic [63:0]      payload_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       in_fire;

  cftp_pkg::char_class_t cls;
  cftp_pkg::result_t     res;
  logic                  res_valid;

  // a last character may only move on when the result slot is free
  assign s1_fire    = s1_valid_q && !(s1_last_q && res_valid && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload of the input stage, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_code_i;
      s1_last_q <= is_last_i;
    end
  end

  cftp_char_class u_char_class (
    .char_i (s1_char_q),
    .cls_o  (cls)
  );

  cftp_parser #(
    .MaxDataBytes (MaxDataBytes)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s1_fire),
    .last_i      (s1_last_q),
    .cls_i       (cls),
    .out_ready_i (out_ready_i),
    .out_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o      = res_valid;
  assign status_o         = res.status;
  assign can_id_o         = res.can_id;
  assign remote_request_o = res.remote_request;
  assign data_length_o    = res.data_length;
  assign payload_o        = res.payload;

  // checks
  `CFTP_ASSERT_NOW(a_err_fields_zero, clk_i, rst_ni, out_valid_o && status_o, can_id_o == 12'd0 && !remote_request_o && data_length_o == 4'd0 && payload_o == 64'd0, "error result carries nonzero fields")
  `CFTP_ASSERT_NOW(a_rtr_no_payload, clk_i, rst_ni, out_valid_o && remote_request_o, payload_o == 64'd0 && !status_o, "remote frame carries payload")
  `CFTP_ASSERT_NOW(a_len_range, clk_i, rst_ni, out_valid_o, data_length_o <= 4'd8, "data length above eight")
  `CFTP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && s1_last_q && res_valid && !out_ready_i, "input stalled without a blocked result")
  `CFTP_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, s1_fire && s1_last_q, res_valid, "last character produced no result")

endmodule

`default_nettype wire

FILE: rtl/cftp_char_class.sv
// character decoder: hex value and special character flags
// depends on cftp_pkg
`default_nettype none

module cftp_char_class (
  input  wire logic [7:0]          char_i,
  output cftp_pkg::char_class_t    cls_o
);

  always_comb begin
    cls_o = '0;
    if (char_i inside {[8'h30:8'h39]}) begin
      cls_o.hex_ok  = 1'b1;
      cls_o.hex_val = char_i[3:0];
    end else if (char_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      // 'A'..'F' and 'a'..'f' share the low three bits
      cls_o.hex_ok  = 1'b1;
      cls_o.hex_val = 4'(char_i[2:0]) + 4'd9;
    end
    cls_o.dlc_ok  = char_i inside {[8'h30:8'h38]};
    cls_o.is_hash = (char_i == cftp_pkg::CharHash);
    cls_o.is_dot  = (char_i == cftp_pkg::CharDot);
    cls_o.is_rtr  = (char_i == cftp_pkg::CharR) || (char_i == cftp_pkg::CharRLow);
  end

endmodule

`default_nettype wire

FILE: rtl/cftp_parser.sv
// parse state machine and result register
// depends on cftp_pkg
`default_nettype none

module cftp_parser #(
  parameter int MaxDataBytes = cftp_pkg::DefMaxDataBytes
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  take_i,
  input  wire logic                  last_i,
  input  cftp_pkg::char_class_t      cls_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output cftp_pkg::result_t          res_o
);

  typedef enum logic [2:0] {
    PhHead, PhFirst, PhByteStart, PhNeedHigh, PhNeedLow, PhRtrDlc, PhDone
  } phase_e;

  phase_e      phase_q, phase_d, phase_upd;
  logic [1:0]  pos_q, pos_d;
  logic [11:0] id_q, id_d, id_upd;
  logic [3:0]  count_q, count_d, count_upd;
  logic [3:0]  nib_q, nib_d, nib_upd;
  logic [63:0] pay_q, pay_d, pay_upd;
  logic        rtr_q, rtr_d, rtr_upd;
  logic [3:0]  dlc_q, dlc_d, dlc_upd;
  logic        err_q, err_d, err_upd;
  logic        out_valid_q, out_valid_d;
  cftp_pkg::result_t res_q, res_d;

  logic        start_byte;
  logic        bad;
  logic [7:0]  data_byte;

  assign data_byte = {nib_q, cls_i.hex_val};

  always_comb begin
    phase_upd  = phase_q;
    id_upd     = id_q;
    count_upd  = count_q;
    nib_upd    = nib_q;
    pay_upd    = pay_q;
    rtr_upd    = rtr_q;
    dlc_upd    = dlc_q;
    err_upd    = err_q;
    start_byte = 1'b0;

    if (take_i && !err_q) begin
      case (phase_q)
        PhHead: begin
          if (pos_q != 2'd3) begin
            if (cls_i.hex_ok) id_upd = {id_q[7:0], cls_i.hex_val};
            else err_upd = 1'b1;
          end else if (cls_i.is_hash) begin
            phase_upd = PhFirst;
          end else begin
            err_upd = 1'b1;
          end
        end
        PhFirst: begin
          if (cls_i.is_rtr) begin
            rtr_upd   = 1'b1;
            phase_upd = PhRtrDlc;
          end else begin
            start_byte = 1'b1;
          end
        end
        PhByteStart: start_byte = 1'b1;
        PhNeedHigh: begin
          if (cls_i.hex_ok) begin
            nib_upd   = cls_i.hex_val;
            phase_upd = PhNeedLow;
          end else begin
            err_upd = 1'b1;
          end
        end
        PhNeedLow: begin
          if (cls_i.hex_ok) begin
            pay_upd   = pay_q | (64'(data_byte) << {count_q[2:0], 3'b000});
            count_upd = count_q + 4'd1;
            phase_upd = (count_upd >= 4'(MaxDataBytes)) ? PhDone : PhByteStart;
          end else begin
            err_upd = 1'b1;
          end
        end
        PhRtrDlc: begin
          if (cls_i.dlc_ok) dlc_upd = cls_i.hex_val;
          phase_upd = PhDone;
        end
        default: ;
      endcase

      // optional separator, else the high nibble
      if (start_byte) begin
        if (cls_i.is_dot) begin
          phase_upd = PhNeedHigh;
        end else if (cls_i.hex_ok) begin
          nib_upd   = cls_i.hex_val;
          phase_upd = PhNeedLow;
        end else begin
          err_upd = 1'b1;
        end
      end
    end
  end

  assign bad = err_upd || (phase_upd == PhHead) || (phase_upd == PhNeedLow);

  always_comb begin
    pos_d   = (take_i && pos_q != 2'd3) ? pos_q + 2'd1 : pos_q;
    phase_d = phase_upd;
    id_d    = id_upd;
    count_d = count_upd;
    nib_d   = nib_upd;
    pay_d   = pay_upd;
    rtr_d   = rtr_upd;
    dlc_d   = dlc_upd;
    err_d   = err_upd;
    if (take_i && last_i) begin
      // back to the start of a new text
      pos_d   = '0;
      phase_d = PhHead;
      id_d    = '0;
      count_d = '0;
      nib_d   = '0;
      pay_d   = '0;
      rtr_d   = 1'b0;
      dlc_d   = '0;
      err_d   = 1'b0;
    end

    res_d                = res_q;
    out_valid_d          = out_valid_q;
    if (take_i && last_i) begin
      out_valid_d          = 1'b1;
      res_d.status         = bad;
      res_d.can_id         = bad ? '0 : id_upd;
      res_d.remote_request = !bad && rtr_upd;
      res_d.data_length    = bad ? '0 : (rtr_upd ? dlc_upd : count_upd);
      res_d.payload        = (bad || rtr_upd) ? '0 : pay_upd;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHead;
      pos_q       <= '0;
      id_q        <= '0;
      count_q     <= '0;
      nib_q       <= '0;
      pay_q       <= '0;
      rtr_q       <= 1'b0;
      dlc_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      id_q        <= id_d;
      count_q     <= count_d;
      nib_q       <= nib_d;
      pay_q       <= pay_d;
      rtr_q       <= rtr_d;
      dlc_q       <= dlc_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: tb/can_frame_text_parser_unit_tb.sv
// self-checking testbench for can_frame_text_parser_unit: sends frame texts one character
// per transfer and checks every result against its own parser model
// depends on cftp_pkg and the can_frame_text_parser_unit rtl
`default_nettype none

module can_frame_text_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_q_t[$];

  // parse phases of the text, identifier digits first
  typedef enum logic [2:0] {
    PhHead,
    PhFirst,
    PhByteStart,
    PhNeedHigh,
    PhNeedLow,
    PhRtrDlc,
    PhDone
  } parse_phase_e;

  localparam int MaxBytes = cftp_pkg::DefMaxDataBytes;
  localparam int RtrDlcLimit = 8;
  localparam logic [4:0] NibbleBad = 5'h10;
  localparam int RandomChars = 1100;
  localparam int TotalChars = 1300;

  // clock, reset and dut ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] char_code_i = 8'h30;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [11:0] can_id_o;
  logic remote_request_o;
  logic [3:0] data_length_o;
  logic [63:0] payload_o;

  // parser model state, mirrors the block for the text in progress
  logic [4:0] char_pos;
  parse_phase_e parse_phase;
  logic [11:0] id_acc;
  logic [3:0] byte_cnt;
  logic [4:0] hi_nib;      // bit 4 marks a held high nibble
  logic [63:0] pay_acc;
  logic rtr_flag;
  logic [3:0] dlc_val;
  logic err_flag;

  // results predicted but not yet seen on the output channel
  cftp_pkg::result_t expected_q[$];

  int fail_count = 0;
  int chars_sent = 0;
  int src_idle_pct = 0;    // chance per character of an input gap
  int sink_idle_pct = 0;   // chance per cycle of an output stall
  int sink_hold = 0;
  string hex_digits = "0123456789ABCDEFabcdef";

  can_frame_text_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .can_id_o        (can_id_o),
    .remote_request_o(remote_request_o),
    .data_length_o   (data_length_o),
    .payload_o       (payload_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  // hex digit value, NibbleBad for anything else (codes above 127 included)
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
    if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
    if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 8'd10)};
    return NibbleBad;
  endfunction

  // back to the state after reset, ready for a new text
  task automatic clear_parser();
    char_pos = '0;
    parse_phase = PhHead;
    id_acc = '0;
    byte_cnt = '0;
    hi_nib = '0;
    pay_acc = '0;
    rtr_flag = 1'b0;
    dlc_val = '0;
    err_flag = 1'b0;
  endtask

  // start of a data byte: one optional separator or the high nibble
  task automatic open_byte(input logic [7:0] ch, input logic [4:0] nib);
    if (ch == cftp_pkg::CharDot) begin
      parse_phase = PhNeedHigh;
    end else if (nib[4]) begin
      err_flag = 1'b1;
    end else begin
      hi_nib = {1'b1, nib[3:0]};
      parse_phase = PhNeedLow;
    end
  endtask

  // advance the model by one accepted character, queue a result on the last one
  task automatic predict_char(input logic [7:0] ch, input logic last);
    logic [4:0] nib;
    logic [63:0] lane;
    cftp_pkg::result_t res;
    nib = hex_nibble(ch);
    // once an error is seen the rest of the text is skipped
    if (!err_flag) begin
      case (parse_phase)
        PhHead: begin
          if (char_pos < 5'd3) begin
            if (nib[4]) err_flag = 1'b1;
            else id_acc = {id_acc[7:0], nib[3:0]};
          end else if (ch == cftp_pkg::CharHash) begin
            parse_phase = PhFirst;
          end else begin
            err_flag = 1'b1;
          end
        end
        PhFirst: begin
          if (ch == cftp_pkg::CharR || ch == cftp_pkg::CharRLow) begin
            rtr_flag = 1'b1;
            parse_phase = PhRtrDlc;
          end else begin
            open_byte(ch, nib);
          end
        end
        PhByteStart: open_byte(ch, nib);
        PhNeedHigh: begin
          if (nib[4]) begin
            err_flag = 1'b1;
          end else begin
            hi_nib = {1'b1, nib[3:0]};
            parse_phase = PhNeedLow;
          end
        end
        PhNeedLow: begin
          if (nib[4]) begin
            err_flag = 1'b1;
          end else begin
            lane = 64'({hi_nib[3:0], nib[3:0]});
            pay_acc = pay_acc | (lane << (8 * byte_cnt[2:0]));
            hi_nib = '0;
            byte_cnt = byte_cnt + 4'd1;
            parse_phase = (byte_cnt >= MaxBytes) ? PhDone : PhByteStart;
          end
        end
        PhRtrDlc: begin
          // only 0 to 8 sets the dlc, anything else is ignored
          if (nib <= RtrDlcLimit) dlc_val = nib[3:0];
          parse_phase = PhDone;
        end
        default: ;
      endcase
    end
    if (char_pos < 5'd31) char_pos = char_pos + 5'd1;

    if (last) begin
      res = '0;
      // an error, too short, or the text ends inside a byte
      if (err_flag || parse_phase == PhHead || parse_phase == PhNeedLow) begin
        res.status = 1'b1;
      end else if (rtr_flag) begin
        res.can_id = id_acc;
        res.remote_request = 1'b1;
        res.data_length = dlc_val;
      end else begin
        res.can_id = id_acc;
        res.data_length = byte_cnt;
        res.payload = pay_acc;
      end
      expected_q.push_back(res);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one character transfer; valid stays high afterwards unless a gap follows,
  // so back-to-back characters never drop valid in between
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= ch;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_text(input char_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly well-formed texts with random content, the rest broken or noise
  function automatic char_q_t random_text();
    char_q_t t;
    int kind;
    int n;
    int pick;
    kind = $urandom_range(0, 99);
    repeat (3) t.push_back(rand_hex());
    t.push_back(cftp_pkg::CharHash);
    if (kind < 25) begin
      // remote frame with an optional dlc character and maybe a tail
      t.push_back($urandom_range(0, 1) ? cftp_pkg::CharR : cftp_pkg::CharRLow);
      pick = $urandom_range(0, 4);
      if (pick == 1) t.push_back(8'("0" + $urandom_range(0, 8)));
      else if (pick == 2) t.push_back(rand_hex());
      else if (pick == 3) t.push_back(rand_char());
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) t.push_back(rand_char());
    end else begin
      // data frame, some beyond the byte limit
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) t.push_back(cftp_pkg::CharDot);
        t.push_back(rand_hex());
        t.push_back(rand_hex());
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) t.push_back(cftp_pkg::CharDot);
      else if (pick == 1) t.push_back(rand_hex());
    end
    // corrupt a fifth of them
    if (kind >= 80) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        t.delete();
        repeat ($urandom_range(1, 10)) t.push_back(rand_char());
      end else if (pick == 1) begin
        t[$urandom_range(0, t.size() - 1)] = rand_char();
      end else if (t.size() > 1) begin
        void'(t.pop_back());
      end
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // ready with random stall bursts
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      sink_hold = $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    cftp_pkg::result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no text pending: status %0b id %h",
               status_o, can_id_o);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0b actual %0b", exp_res.status, status_o);
          fail_count++;
        end
        if (can_id_o !== exp_res.can_id) begin
          $error("can_id: expected %h actual %h", exp_res.can_id, can_id_o);
          fail_count++;
        end
        if (remote_request_o !== exp_res.remote_request) begin
          $error("remote_request: expected %0b actual %0b",
                 exp_res.remote_request, remote_request_o);
          fail_count++;
        end
        if (data_length_o !== exp_res.data_length) begin
          $error("data_length: expected %0d actual %0d", exp_res.data_length, data_length_o);
          fail_count++;
        end
        if (payload_o !== exp_res.payload) begin
          $error("payload: expected %h actual %h", exp_res.payload, payload_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lowest and highest identifiers, mixed case digits
  task automatic test_identifier_extremes();
    send_text(to_chars("000#"));
    send_text(to_chars("FFF#"));
    send_text(to_chars("fFf#00"));
  endtask

  // data frames: separators, full payload with an ignored tail, trailing separator
  task automatic test_data_frames();
    send_text(to_chars("123#DEADBEEF"));
    send_text(to_chars("7A5#11.22.33.44.55.66.77.88"));
    send_text(to_chars("1aB#0011223344556677XYZ"));
    send_text(to_chars("456#12."));
    send_text(to_chars("456#."));
  endtask

  // remote frames: no dlc, dlc 8, dlc out of range, ignored tail, non-digit
  task automatic test_remote_frames();
    send_text(to_chars("123#R"));
    send_text(to_chars("123#r8"));
    send_text(to_chars("123#R9"));
    send_text(to_chars("123#R0junk"));
    send_text(to_chars("7FF#RZ"));
  endtask

  // short text, missing delimiter, bad digits, odd digit count, double separator
  task automatic test_malformed();
    send_text(to_chars("1"));
    send_text(to_chars("12#"));
    send_text(to_chars("1234"));
    send_text(to_chars("12G#00"));
    send_text(to_chars("123#ABC"));
    send_text(to_chars("123#1G"));
    send_text(to_chars("123#..11"));
  endtask

  // codes above 127 and a control code never act as digits, delimiter, separator or r
  task automatic test_odd_codes();
    char_q_t t;
    t = to_chars("1x3#00"); t[1] = 8'h80; send_text(t);
    t = to_chars("123x00"); t[3] = 8'hA3; send_text(t);
    t = to_chars("123#x5"); t[4] = 8'hD2; send_text(t);
    t = to_chars("123#x11"); t[4] = 8'hAE; send_text(t);
    t = to_chars("123#1x"); t[5] = 8'hFF; send_text(t);
    t = to_chars("123#Rx"); t[5] = 8'hB0; send_text(t);
    t = to_chars("x23#"); t[0] = 8'h01; send_text(t);
  endtask

  // random texts; idling changes per text so some stretches run without gaps
  task automatic test_random_traffic();
    int mode;
    while (chars_sent < RandomChars) begin
      mode = $urandom_range(0, 3);
      src_idle_pct = (mode == 0) ? 0 : (mode == 1) ? 10 : 40;
      sink_idle_pct = (mode == 2) ? 0 : (mode == 3) ? 30 : 8;
      send_text(random_text());
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    while (chars_sent < TotalChars) send_text(random_text());
  endtask

  initial begin
    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 20;
    sink_idle_pct = 15;
    test_identifier_extremes();
    test_data_frames();
    test_remote_frames();
    test_malformed();
    test_odd_codes();
    test_random_traffic();
    test_back_to_back();
    in_valid_i <= 1'b0;

    // drain the output, then wait for any stray transfer
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (expected_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/cftp_pkg.sv
rtl/cftp_char_class.sv
rtl/cftp_parser.sv
rtl/can_frame_text_parser_unit.sv
tb/can_frame_text_parser_unit_tb.sv
